// File: sv/pdve_pkg.sv
// Shared types, constants and tables for the pose-difference velocity estimator.
package pdve_pkg;
  localparam int POS_W   = 32;
  localparam int ANG_W   = 16;
  localparam int TPS_W   = 30;
  localparam int TICK_W  = 24;
  localparam int OUT_W   = 32;
  localparam int DIFF_W  = POS_W + 1;
  localparam int DYAW_W  = ANG_W + 1;
  localparam int VEC_W   = POS_W + 8;
  localparam int Z_W     = 32;
  localparam int STEPS   = 30;
  localparam int STEP_W  = 5;
  localparam int GFRAC   = 30;
  localparam int ACC_W   = VEC_W + TPS_W + 1;
  localparam int QUO_W   = 32;

  localparam logic [TPS_W-1:0] TPS_RESET = 30'd1000000;
  localparam logic [30:0]      GAIN_Q30  = 31'd652032874;

  typedef struct packed {
    logic signed [DIFF_W-1:0] dx;
    logic signed [DIFF_W-1:0] dy;
    logic [ANG_W-1:0]         heading;
    logic signed [DYAW_W-1:0] dyaw;
    logic [TICK_W-1:0]        ticks;
  } job_t;

  typedef struct packed {
    logic full;
    logic empty;
  } fifo_stat_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_ROT, ST_GMUL, ST_GADD, ST_SSET, ST_SMUL, ST_SCHK, ST_SDIV, ST_PUSH
  } back_st_e;

  // atan(2^-i), pi = 2^31
  function automatic logic [Z_W-1:0] atan_lut(input logic [STEP_W-1:0] i);
    logic [Z_W-1:0] v;
    case (i)
      5'd0:  v = 32'h20000000;
      5'd1:  v = 32'h12E4051E;
      5'd2:  v = 32'h09FB385B;
      5'd3:  v = 32'h051111D4;
      5'd4:  v = 32'h028B0D43;
      5'd5:  v = 32'h0145D7E1;
      5'd6:  v = 32'h00A2F61E;
      5'd7:  v = 32'h00517C55;
      5'd8:  v = 32'h0028BE53;
      5'd9:  v = 32'h00145F2F;
      5'd10: v = 32'h000A2F98;
      5'd11: v = 32'h000517CC;
      5'd12: v = 32'h00028BE6;
      5'd13: v = 32'h000145F3;
      5'd14: v = 32'h0000A2FA;
      5'd15: v = 32'h0000517D;
      5'd16: v = 32'h000028BE;
      5'd17: v = 32'h0000145F;
      5'd18: v = 32'h00000A30;
      5'd19: v = 32'h00000518;
      5'd20: v = 32'h0000028C;
      5'd21: v = 32'h00000146;
      5'd22: v = 32'h000000A3;
      5'd23: v = 32'h00000051;
      5'd24: v = 32'h00000029;
      5'd25: v = 32'h00000014;
      5'd26: v = 32'h0000000A;
      5'd27: v = 32'h00000005;
      5'd28: v = 32'h00000003;
      5'd29: v = 32'h00000001;
      default: v = '0;
    endcase
    return v;
  endfunction
endpackage

// File: sv/pdve_in_if.sv
// Pose sample channel.
interface pdve_in_if;
  logic                             valid;
  logic                             ready;
  logic signed [pdve_pkg::POS_W-1:0] pos_x;
  logic signed [pdve_pkg::POS_W-1:0] pos_y;
  logic signed [pdve_pkg::ANG_W-1:0] heading;
  logic [pdve_pkg::TICK_W-1:0]       elapsed_ticks;
  modport source (output valid, pos_x, pos_y, heading, elapsed_ticks, input ready);
  modport sink (input valid, pos_x, pos_y, heading, elapsed_ticks, output ready);
endinterface

// File: sv/pdve_out_if.sv
// Velocity result channel.
interface pdve_out_if;
  logic                              valid;
  logic                              ready;
  logic signed [pdve_pkg::OUT_W-1:0] vel_forward;
  logic signed [pdve_pkg::OUT_W-1:0] vel_lateral;
  logic signed [pdve_pkg::OUT_W-1:0] turn_rate;
  modport source (output valid, vel_forward, vel_lateral, turn_rate, input ready);
  modport sink (input valid, vel_forward, vel_lateral, turn_rate, output ready);
endinterface

// File: sv/pose_difference_velocity_estimator_top.sv
// Top level of the pose-difference velocity estimator.
//   channel  dir  handshake          payload
//   in_i     in   valid/ready        pos_x, pos_y, heading, elapsed_ticks
//   out_o    out  valid/ready        vel_forward, vel_lateral, turn_rate
//   cfg      in   cfg_we_i           cfg_wdata_i (ticks_per_second)
// Each sample after the first passes through the back end: 30 CORDIC steps, the gain
// multiply, then per output 30 shift-add multiply steps and a 32-step divide.
// The front takes samples at once while the two-entry queue has room.
// Reset clears the stored sample flag, the queue and the sequencer; tick rate
// resets to 1000000. A held result stalls only the last sequencer state.
module pose_difference_velocity_estimator_top (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [pdve_pkg::TPS_W-1:0] cfg_wdata_i,
  pdve_in_if.sink                    in_i,
  pdve_out_if.source                 out_o
);
  import pdve_pkg::*;

  logic [TPS_W-1:0] tps_q;
  job_t             fjob, bjob;
  fifo_stat_t       stat;
  logic             push, pop;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) tps_q <= TPS_RESET;
    else if (cfg_we_i) tps_q <= cfg_wdata_i;
  end

  pdve_front u_front (
    .clk_i, .rst_ni, .in_i, .stat_i(stat), .job_o(fjob), .push_o(push)
  );

  pdve_fifo u_fifo (
    .clk_i, .rst_ni, .push_i(push), .job_i(fjob), .pop_i(pop), .job_o(bjob), .stat_o(stat)
  );

  pdve_back u_back (
    .clk_i, .rst_ni, .job_i(bjob), .stat_i(stat), .tps_i(tps_q), .pop_o(pop), .out_o
  );

  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> !stat.full) else $error("push into full queue");
  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> !stat.empty) else $error("pop from empty queue");
  a_pop_spaced: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |=> !pop) else $error("back end took two jobs in a row");
endmodule

// File: sv/pdve_front.sv
// Front end: takes pose samples, keeps the previous one, forms difference jobs.
module pdve_front (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  pdve_in_if.sink              in_i,
  input  pdve_pkg::fifo_stat_t stat_i,
  output pdve_pkg::job_t       job_o,
  output logic                 push_o
);
  import pdve_pkg::*;

  logic                     have_q;
  logic signed [POS_W-1:0]  prev_x_q, prev_y_q;
  logic [ANG_W-1:0]         prev_h_q;
  logic                     acc;
  logic [ANG_W-1:0]         dh;

  assign in_i.ready = !stat_i.full;
  assign acc        = in_i.valid && in_i.ready;
  assign push_o     = acc && have_q;

  assign dh           = in_i.heading - prev_h_q;
  assign job_o.dx     = {in_i.pos_x[POS_W-1], in_i.pos_x} - {prev_x_q[POS_W-1], prev_x_q};
  assign job_o.dy     = {in_i.pos_y[POS_W-1], in_i.pos_y} - {prev_y_q[POS_W-1], prev_y_q};
  assign job_o.heading = in_i.heading;
  // half turn: -pi counts as +pi
  assign job_o.dyaw   = (dh == {1'b1, {(ANG_W-1){1'b0}}}) ? {2'b01, {(ANG_W-1){1'b0}}}
                                                          : {dh[ANG_W-1], dh};
  assign job_o.ticks  = (in_i.elapsed_ticks == '0) ? TICK_W'(1) : in_i.elapsed_ticks;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      have_q   <= 1'b0;
      prev_x_q <= '0;
      prev_y_q <= '0;
      prev_h_q <= '0;
    end else if (acc) begin
      have_q   <= 1'b1;
      prev_x_q <= in_i.pos_x;
      prev_y_q <= in_i.pos_y;
      prev_h_q <= in_i.heading;
    end
  end
endmodule

// File: sv/pdve_fifo.sv
// Two-entry job queue between front and back.
module pdve_fifo (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  pdve_pkg::job_t       job_i,
  input  logic                 pop_i,
  output pdve_pkg::job_t       job_o,
  output pdve_pkg::fifo_stat_t stat_o
);
  import pdve_pkg::*;

  job_t       mem_q [2];
  logic       wr_q, rd_q;
  logic [1:0] cnt_q;

  assign stat_o.full  = (cnt_q == 2'd2);
  assign stat_o.empty = (cnt_q == 2'd0);
  assign job_o        = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= job_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= !wr_q;
      if (pop_i)  rd_q <= !rd_q;
      cnt_q <= cnt_q + 2'(push_i) - 2'(pop_i);
    end
  end
endmodule

// File: sv/pdve_back.sv
// Back end: CORDIC rotation, gain correction, rate scaling and the output register.
module pdve_back (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  pdve_pkg::job_t           job_i,
  input  pdve_pkg::fifo_stat_t     stat_i,
  input  logic [pdve_pkg::TPS_W-1:0] tps_i,
  output logic                     pop_o,
  pdve_out_if.source               out_o
);
  import pdve_pkg::*;

  back_st_e                 st_q, st_d;
  logic signed [VEC_W-1:0]  vx_q, vx_d, vy_q, vy_d;
  logic [Z_W-1:0]           z_q, z_d;
  logic [STEP_W-1:0]        step_q, step_d;
  logic [1:0]               ch_q, ch_d;
  logic [TICK_W-1:0]        ticks_q, ticks_d;
  logic signed [DYAW_W-1:0] dyaw_q, dyaw_d;
  logic [TPS_W-1:0]         tps_q, tps_d;
  logic signed [41:0]       phi_q, phi_d;
  logic [60:0]              plo_q, plo_d;
  logic [VEC_W-1:0]         mag_q, mag_d;
  logic                     neg_q, neg_d;
  logic [ACC_W-1:0]         acc_q, acc_d;
  logic [TICK_W-1:0]        rem_q, rem_d;
  logic [QUO_W-1:0]         quo_q, quo_d, num_q, num_d;
  logic                     sat_q, sat_d;
  logic [OUT_W-1:0]         res_q [3];
  logic [OUT_W-1:0]         res_d;
  logic                     res_we;
  logic                     ov_q, ov_d, load_out;

  logic [Z_W-1:0]           z0, zt;
  logic signed [VEC_W-1:0]  sx, sy, gv, dsel;
  logic signed [9:0]        ghi;
  logic signed [31:0]       gs;
  logic [60:0]              rnd;
  logic signed [41:0]       gsum;
  logic [25:0]              trial;
  logic [QUO_W-1:0]         quo_n, lim, total;

  assign out_o.valid       = ov_q;
  assign out_o.vel_forward = res_q[0];
  assign out_o.vel_lateral = res_q[1];
  assign out_o.turn_rate   = res_q[2];

  always_comb begin
    st_d = st_q; vx_d = vx_q; vy_d = vy_q; z_d = z_q; step_d = step_q; ch_d = ch_q;
    ticks_d = ticks_q; dyaw_d = dyaw_q; tps_d = tps_q; phi_d = phi_q; plo_d = plo_q;
    mag_d = mag_q; neg_d = neg_q; acc_d = acc_q; rem_d = rem_q; quo_d = quo_q;
    num_d = num_q; sat_d = sat_q; res_d = '0; res_we = 1'b0; pop_o = 1'b0;
    load_out = 1'b0;
    ov_d = ov_q && !out_o.ready;

    z0    = Z_W'(0) - {job_i.heading, {(Z_W-ANG_W){1'b0}}};
    zt    = z0 + 32'h4000_0000;
    sx    = vx_q >>> step_q;
    sy    = vy_q >>> step_q;
    gv    = ch_q[0] ? vy_q : vx_q;
    ghi   = gv[VEC_W-1:GFRAC];
    gs    = {1'b0, GAIN_Q30};
    rnd   = plo_q + 61'(1 << (GFRAC-1));
    gsum  = phi_q + $signed({11'b0, rnd[60:GFRAC]});
    dsel  = (ch_q == 2'd0) ? vx_q : (ch_q == 2'd1) ? vy_q : VEC_W'(dyaw_q);
    trial = {1'b0, rem_q, num_q[QUO_W-1]} - {2'b0, ticks_q};
    quo_n = {quo_q[QUO_W-2:0], !trial[25]};
    lim   = neg_q ? 32'h8000_0000 : 32'h7FFF_FFFF;
    total = (sat_q || quo_n > lim) ? lim : quo_n;

    case (st_q)
      ST_IDLE: begin
        if (!stat_i.empty) begin
          pop_o   = 1'b1;
          ticks_d = job_i.ticks;
          dyaw_d  = job_i.dyaw;
          tps_d   = tps_i;
          step_d  = '0;
          // fold headings beyond a quarter turn by negating the vector
          if (zt[Z_W-1]) begin
            vx_d = -VEC_W'(job_i.dx);
            vy_d = -VEC_W'(job_i.dy);
            z_d  = z0 + 32'h8000_0000;
          end else begin
            vx_d = VEC_W'(job_i.dx);
            vy_d = VEC_W'(job_i.dy);
            z_d  = z0;
          end
          st_d = ST_ROT;
        end
      end
      ST_ROT: begin
        if (!z_q[Z_W-1]) begin
          vx_d = vx_q - sy; vy_d = vy_q + sx; z_d = z_q - atan_lut(step_q);
        end else begin
          vx_d = vx_q + sy; vy_d = vy_q - sx; z_d = z_q + atan_lut(step_q);
        end
        step_d = step_q + 1'b1;
        if (step_q == STEP_W'(STEPS-1)) begin
          ch_d = '0;
          st_d = ST_GMUL;
        end
      end
      ST_GMUL: begin
        phi_d = 42'(ghi) * 42'(gs);
        plo_d = 61'(gv[GFRAC-1:0]) * 61'(GAIN_Q30);
        st_d  = ST_GADD;
      end
      ST_GADD: begin
        if (ch_q[0]) begin
          vy_d = gsum[VEC_W-1:0];
          ch_d = '0;
          st_d = ST_SSET;
        end else begin
          vx_d = gsum[VEC_W-1:0];
          ch_d = 2'd1;
          st_d = ST_GMUL;
        end
      end
      ST_SSET: begin
        neg_d  = dsel[VEC_W-1];
        mag_d  = dsel[VEC_W-1] ? VEC_W'(-dsel) : VEC_W'(dsel);
        acc_d  = '0;
        step_d = STEP_W'(TPS_W-1);
        st_d   = ST_SMUL;
      end
      ST_SMUL: begin
        // shift-add multiply, tick rate MSB first; last step adds half a divisor
        acc_d = {acc_q[ACC_W-2:0], 1'b0} + (tps_q[step_q] ? ACC_W'(mag_q) : '0);
        if (step_q == '0) begin
          acc_d = acc_d + ACC_W'(ticks_q >> 1);
          st_d  = ST_SCHK;
        end else begin
          step_d = step_q - 1'b1;
        end
      end
      ST_SCHK: begin
        sat_d  = (acc_q[ACC_W-1:QUO_W] >= (ACC_W-QUO_W)'(ticks_q));
        rem_d  = acc_q[QUO_W +: TICK_W];
        num_d  = acc_q[QUO_W-1:0];
        quo_d  = '0;
        step_d = STEP_W'(QUO_W-1);
        st_d   = ST_SDIV;
      end
      ST_SDIV: begin
        rem_d  = trial[25] ? {rem_q[TICK_W-2:0], num_q[QUO_W-1]} : trial[TICK_W-1:0];
        quo_d  = quo_n;
        num_d  = {num_q[QUO_W-2:0], 1'b0};
        step_d = step_q - 1'b1;
        if (step_q == '0) begin
          res_d  = neg_q ? -total : total;
          res_we = 1'b1;
          if (ch_q == 2'd2) st_d = ST_PUSH;
          else begin
            ch_d = ch_q + 1'b1;
            st_d = ST_SSET;
          end
        end
      end
      ST_PUSH: begin
        if (!ov_q || out_o.ready) begin
          load_out = 1'b1;
          ov_d     = 1'b1;
          st_d     = ST_IDLE;
        end
      end
      default: st_d = ST_IDLE;
    endcase
  end

  // results stage in a scratch set and move to the output register together
  logic [OUT_W-1:0] stage_q [3];

  always_ff @(posedge clk_i) begin
    vx_q <= vx_d; vy_q <= vy_d; z_q <= z_d; step_q <= step_d; ch_q <= ch_d;
    ticks_q <= ticks_d; dyaw_q <= dyaw_d; tps_q <= tps_d; phi_q <= phi_d; plo_q <= plo_d;
    mag_q <= mag_d; neg_q <= neg_d; acc_q <= acc_d; rem_q <= rem_d; quo_q <= quo_d;
    num_q <= num_d; sat_q <= sat_d;
    if (res_we) stage_q[ch_q] <= res_d;
    if (load_out) begin
      res_q[0] <= stage_q[0];
      res_q[1] <= stage_q[1];
      res_q[2] <= stage_q[2];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= ST_IDLE;
      ov_q <= 1'b0;
    end else begin
      st_q <= st_d;
      ov_q <= ov_d;
    end
  end
endmodule
